// ----- design/mhpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared constants, types and codes of the max-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KID_W      = ADDR_W + 2;

   typedef enum logic [0:0] {
      REQ_PUSH = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_POP_RD,
      S_DN_L,
      S_DN_R,
      S_DN_C,
      S_FIN
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             done;
      status_type       status;
      logic [CNT_W-1:0] count;
   } eng_rsp_type;

endpackage
`default_nettype wire

// ----- design/max_heap_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// binary max-heap of signed values in one ram, push or pop per transaction
// a pop's sift-down is paced by the one ram read port (two reads per
// sift-down level).
// throughput: one transaction at a time, start is taken while busy is low;
// rsp_valid lasts one cycle and cannot be held off.
// reset empties the heap at once; ram contents are not cleared.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [0:0]            req_type,
   input  wire logic [DATA_WIDTH-1:0] req_push_value,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_top_value,
   output logic [CNT_W-1:0]           rsp_item_count,
   output logic                       rsp_is_empty,
   output logic [1:0]                 rsp_status
);

   mem_req_type           mem;
   eng_rsp_type           eng_rsp;
   logic [DATA_WIDTH-1:0] rd_data;

   logic [DATA_WIDTH-1:0] root_ff, root_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_top_ff, rsp_top_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   mhpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   mhpq_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rd_data        (rd_data),
      .busy           (busy),
      .mem            (mem),
      .rsp            (eng_rsp)
   );

   // shadow of the root entry and the response register
   always_comb begin
      root_in = root_ff;
      if (mem.wr_en && mem.wr_addr == '0) begin
         root_in = mem.wr_data;
      end
      rsp_valid_in  = eng_rsp.done;
      rsp_count_in  = eng_rsp.count;
      rsp_empty_in  = (eng_rsp.count == '0);
      rsp_top_in    = rsp_empty_in ? '0 : root_ff;
      rsp_status_in = eng_rsp.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff       <= root_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_top_value  = rsp_top_ff;
   assign rsp_item_count = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

// ----- design/mhpq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- design/mhpq_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_engine
// push / pop sequencer: sift-up and sift-down over the heap ram
// ----------------------------------------------------------------------------
module mhpq_engine import mhpq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [0:0]            req_type,
   input  wire logic [DATA_WIDTH-1:0] req_push_value,
   input  wire logic [DATA_WIDTH-1:0] rd_data,
   output logic                       busy,
   output mem_req_type                mem,
   output eng_rsp_type                rsp
);

   state_type                     state_ff, state_in;
   logic        [CNT_W-1:0]       count_ff, count_in;
   logic        [ADDR_W-1:0]      pos_ff, pos_in;
   logic signed [DATA_WIDTH-1:0]  v_ff, v_in;
   logic signed [DATA_WIDTH-1:0]  left_ff, left_in;
   status_type                    status_ff, status_in;

   logic signed [DATA_WIDTH-1:0]  rd_s;
   logic        [ADDR_W-1:0]      parent;
   logic        [ADDR_W-1:0]      grand;
   logic        [KID_W-1:0]       kid;
   logic        [KID_W-1:0]       kid_r;
   logic        [KID_W-1:0]       kid_next;
   logic signed [DATA_WIDTH-1:0]  child_v;
   logic        [ADDR_W-1:0]      child_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      v_ff    <= v_in;
      left_ff <= left_in;
   end

   always_comb begin
      rd_s     = $signed(rd_data);
      parent   = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
      kid      = {1'b0, pos_ff, 1'b1};
      kid_r    = kid + KID_W'(1);
      child_v  = left_ff;
      child_i  = kid[ADDR_W-1:0];
      grand    = ADDR_W'((parent - ADDR_W'(1)) >> 1);
      kid_next = '0;

      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      v_in      = v_ff;
      left_in   = left_ff;

      mem = '0;
      rsp = '0;
      rsp.status = status_ff;
      rsp.count  = count_ff;
      busy = (state_ff != S_IDLE);

      unique case (state_ff) inside
         S_IDLE: begin
            if (start) begin
               status_in = ST_OK;
               if (req_type == REQ_PUSH) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_FIN;
                  end else begin
                     pos_in   = count_ff[ADDR_W-1:0];
                     v_in     = $signed(req_push_value);
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     if (count_ff == CNT_W'(1)) begin
                        state_in = S_FIN;
                     end else begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = ADDR_W'(count_ff - CNT_W'(1));
                        state_in    = S_POP_RD;
                     end
                  end
               end
            end
         end

         S_UP_RD: begin
            if (pos_ff == '0) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = pos_ff;
               mem.wr_data = v_ff;
               state_in    = S_FIN;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = parent;
               state_in    = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = pos_ff;
            if (v_ff > rd_s) begin
               mem.wr_data = rd_s;
               pos_in      = parent;
               if (parent == '0) begin
                  state_in = S_UP_RD;
               end else begin
                  mem.rd_en   = 1'b1;
                  mem.rd_addr = grand;
               end
            end else begin
               mem.wr_data = v_ff;
               state_in    = S_FIN;
            end
         end

         S_POP_RD: begin
            v_in     = rd_s;
            pos_in   = '0;
            state_in = S_DN_L;
         end

         S_DN_L: begin
            if (kid >= KID_W'(count_ff)) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = pos_ff;
               mem.wr_data = v_ff;
               state_in    = S_FIN;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = kid[ADDR_W-1:0];
               state_in    = S_DN_R;
            end
         end

         S_DN_R, S_DN_C: begin
            if (state_ff == S_DN_R) begin
               left_in = rd_s;
               child_v = rd_s;
            end else if (rd_s > left_ff) begin
               child_v = rd_s;
               child_i = kid_r[ADDR_W-1:0];
            end
            if (state_ff == S_DN_R && kid_r < KID_W'(count_ff)) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = kid_r[ADDR_W-1:0];
               state_in    = S_DN_C;
            end else begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = pos_ff;
               if (child_v > v_ff) begin
                  mem.wr_data = child_v;
                  pos_in      = child_i;
                  kid_next    = {1'b0, child_i, 1'b1};
                  if (kid_next < KID_W'(count_ff)) begin
                     mem.rd_en   = 1'b1;
                     mem.rd_addr = kid_next[ADDR_W-1:0];
                     state_in    = S_DN_R;
                  end else begin
                     state_in = S_DN_L;
                  end
               end else begin
                  mem.wr_data = v_ff;
                  state_in    = S_FIN;
               end
            end
         end

         S_FIN: begin
            rsp.done = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire
